// File: design/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_REAR   = 3'd3;
    localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [2:0] OP_PEEK_REAR  = 3'd5;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] push_data;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] read_data;
        logic [3:0]  entry_count;
        logic        is_empty;
        logic        is_full;
    } rsp_t;

    // One lane keeps the entries in order with its head end at cell zero.
    typedef struct packed {
        logic push_head;
        logic pop_head;
        logic push_tail;
        logic pop_tail;
    } lane_cmd_t;

endpackage

`default_nettype wire

// File: design/cdq_cell.sv
`default_nettype none

module cdq_cell #(
    parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire cdq_pkg::lane_cmd_t cmd,
    input  wire [DATA_WIDTH-1:0]   din,
    input  wire                    lo_valid,
    input  wire [DATA_WIDTH-1:0]   lo_data,
    input  wire                    hi_valid,
    input  wire [DATA_WIDTH-1:0]   hi_data,
    output logic                   valid,
    output logic [DATA_WIDTH-1:0]  data
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (cmd.push_head)
        begin
            valid_next = lo_valid;
            data_next  = lo_data;
        end
        else if (cmd.pop_head)
        begin
            valid_next = hi_valid;
            data_next  = hi_data;
        end
        else if (cmd.push_tail)
        begin
            if (lo_valid && !valid_reg)
            begin
                valid_next = 1'b1;
                data_next  = din;
            end
        end
        else if (cmd.pop_tail)
        begin
            if (valid_reg && !hi_valid)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

// File: design/cdq_lane.sv
`default_nettype none

module cdq_lane #(
    parameter int CELLS      = cdq_pkg::DEPTH_DEFAULT - 1,
    parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire cdq_pkg::lane_cmd_t cmd,
    input  wire [DATA_WIDTH-1:0]   din,
    output logic [DATA_WIDTH-1:0]  head_data
);

    logic [CELLS-1:0]      valid;
    logic [DATA_WIDTH-1:0] data [CELLS];

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        logic                  lo_valid;
        logic [DATA_WIDTH-1:0] lo_data;
        logic                  hi_valid;
        logic [DATA_WIDTH-1:0] hi_data;

        if (i == 0)
        begin : g_first
            assign lo_valid = 1'b1;
            assign lo_data  = din;
        end
        else
        begin : g_mid_lo
            assign lo_valid = valid[i-1];
            assign lo_data  = data[i-1];
        end

        if (i == CELLS - 1)
        begin : g_last
            assign hi_valid = 1'b0;
            assign hi_data  = '0;
        end
        else
        begin : g_mid_hi
            assign hi_valid = valid[i+1];
            assign hi_data  = data[i+1];
        end

        cdq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .din      (din),
            .lo_valid (lo_valid),
            .lo_data  (lo_data),
            .hi_valid (hi_valid),
            .hi_data  (hi_data),
            .valid    (valid[i]),
            .data     (data[i])
        );
    end

    assign head_data = data[0];

endmodule

`default_nettype wire

// File: design/circular_deque.sv
// Latency: a transaction accepted at a clock edge has its result on the result ports
// in the next cycle, marked by done for exactly that cycle.
// Throughput: one transaction per cycle; busy stays low, since every operation is a single
// shift or local load in each cell of the two mirrored cell chains.
// Reset: rst_n clears the count and all occupancy bits, leaving the deque empty.
// The receiver cannot stall; each result is taken in the cycle it is shown.
`default_nettype none

module circular_deque #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    output logic             busy,
    input  wire cdq_pkg::req_t request,
    output logic             done,
    output cdq_pkg::rsp_t    result
);

    localparam int CELLS = DEPTH - 1;
    localparam int CW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;

    // The front lane has the front entry at cell zero, the rear lane the rear entry.
    cdq_pkg::lane_cmd_t    front_cmd;
    cdq_pkg::lane_cmd_t    rear_cmd;
    logic [DATA_WIDTH-1:0] din;
    logic [DATA_WIDTH-1:0] front_head;
    logic [DATA_WIDTH-1:0] rear_head;

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  done_reg;
    cdq_pkg::rsp_t         result_reg;
    cdq_pkg::rsp_t         result_next;

    logic                  empty;
    logic                  full;
    logic                  ok;
    logic [DATA_WIDTH-1:0] rd;
    logic [DATA_WIDTH+31:0] push_ext;
    logic [DATA_WIDTH+31:0] rd_ext;
    logic [CW+3:0]          count_ext;

    assign push_ext = {{DATA_WIDTH{1'b0}}, request.push_data};
    assign din      = push_ext[DATA_WIDTH-1:0];
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(CELLS));

    always_comb
    begin
        front_cmd  = '0;
        rear_cmd   = '0;
        ok         = 1'b0;
        rd         = '0;
        count_next = count_reg;
        if (start)
        begin
            case (request.opcode)
                cdq_pkg::OP_PUSH_FRONT:
                begin
                    if (!full)
                    begin
                        front_cmd.push_head = 1'b1;
                        rear_cmd.push_tail  = 1'b1;
                        ok                  = 1'b1;
                        count_next          = count_reg + CW'(1);
                    end
                end
                cdq_pkg::OP_PUSH_REAR:
                begin
                    if (!full)
                    begin
                        front_cmd.push_tail = 1'b1;
                        rear_cmd.push_head  = 1'b1;
                        ok                  = 1'b1;
                        count_next          = count_reg + CW'(1);
                    end
                end
                cdq_pkg::OP_POP_FRONT:
                begin
                    if (!empty)
                    begin
                        front_cmd.pop_head = 1'b1;
                        rear_cmd.pop_tail  = 1'b1;
                        ok                 = 1'b1;
                        rd                 = front_head;
                        count_next         = count_reg - CW'(1);
                    end
                end
                cdq_pkg::OP_POP_REAR:
                begin
                    if (!empty)
                    begin
                        front_cmd.pop_tail = 1'b1;
                        rear_cmd.pop_head  = 1'b1;
                        ok                 = 1'b1;
                        rd                 = rear_head;
                        count_next         = count_reg - CW'(1);
                    end
                end
                cdq_pkg::OP_PEEK_FRONT:
                begin
                    if (!empty)
                    begin
                        ok = 1'b1;
                        rd = front_head;
                    end
                end
                cdq_pkg::OP_PEEK_REAR:
                begin
                    if (!empty)
                    begin
                        ok = 1'b1;
                        rd = rear_head;
                    end
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase
        end
    end

    assign rd_ext    = {32'b0, rd};
    assign count_ext = {4'b0, count_next};

    always_comb
    begin
        result_next.ok          = ok;
        result_next.read_data   = rd_ext[31:0];
        result_next.entry_count = count_ext[3:0];
        result_next.is_empty    = (count_next == '0);
        result_next.is_full     = (count_next == CW'(CELLS));
    end

    cdq_lane #(
        .CELLS      (CELLS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (front_cmd),
        .din       (din),
        .head_data (front_head)
    );

    cdq_lane #(
        .CELLS      (CELLS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_rear_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (rear_cmd),
        .din       (din),
        .head_data (rear_head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
